// ----- rtl/core/cfe_pkg.sv -----
// Shared constants for the counterflow effectiveness block.
`default_nettype none

package cfe_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int NTU_W   = 24;
  localparam int RATIO_W = 24;
  localparam int TOL_W   = 16;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;
  localparam logic [NTU_W-1:0] NTU_MAX   = 24'hFF_FFFF;

  // Q0.32 arithmetic for the exponential
  localparam logic [32:0] ONE32        = 33'h1_0000_0000;
  localparam logic [31:0] LN2_Q32      = 32'd2977044472;
  localparam int          XW           = 64;
  localparam logic [63:0] EXP_LIMIT    = 64'h20_0000_0000;
  localparam int          XKW          = 38;
  localparam int          KW           = 6;
  localparam int          TAYLOR_TERMS = 14;
  localparam int          RECIP_SHIFT  = 36;

  // register port
  localparam int   APB_AW  = 3;
  localparam int   APB_DW  = 32;
  localparam logic REG_TOL = 1'b0;

endpackage

`default_nettype wire

// ----- rtl/core/cfe_div_cell.sv -----
// One restoring division step: decides one quotient bit and passes the rest on.
`default_nettype none

module cfe_div_cell #(
  parameter int W  = 8,
  parameter int DW = 4,
  parameter int QW = 4,
  parameter int SW = 1,
  parameter int I  = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [W-1:0]  in_rem,
  input  logic [DW-1:0] in_den,
  input  logic [QW-1:0] in_quo,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [W-1:0]  out_rem,
  output logic [DW-1:0] out_den,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic [W-1:0] den_sh;
  logic         fits;

  assign den_sh = W'(in_den) << I;
  assign fits   = in_rem >= den_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_rem  <= fits ? in_rem - den_sh : in_rem;
    out_quo  <= in_quo | (fits ? (QW'(1) << I) : '0);
    out_den  <= in_den;
    out_side <= in_side;
  end

endmodule

`default_nettype wire

// ----- rtl/core/cfe_divider.sv -----
// Pipelined restoring divider: a row of cells, one quotient bit per cell.
`default_nettype none

module cfe_divider #(
  parameter int W  = 8,
  parameter int DW = 4,
  parameter int QW = 4,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [W-1:0]  in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [W-1:0]  out_rem,
  output logic [SW-1:0] out_side
);

  logic          vld  [QW+1];
  logic [W-1:0]  rem  [QW+1];
  logic [DW-1:0] den  [QW+1];
  logic [QW-1:0] quo  [QW+1];
  logic [SW-1:0] side [QW+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = in_num;
  assign den[0]  = in_den;
  assign quo[0]  = '0;
  assign side[0] = in_side;

  for (genvar g = 0; g < QW; g++) begin : g_cell
    cfe_div_cell #(
      .W(W), .DW(DW), .QW(QW), .SW(SW), .I(QW - 1 - g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (vld[g]),
      .in_rem   (rem[g]),
      .in_den   (den[g]),
      .in_quo   (quo[g]),
      .in_side  (side[g]),
      .out_valid(vld[g+1]),
      .out_rem  (rem[g+1]),
      .out_den  (den[g+1]),
      .out_quo  (quo[g+1]),
      .out_side (side[g+1])
    );
  end

  assign out_valid = vld[QW];
  assign out_quo   = quo[QW];
  assign out_rem   = rem[QW];
  assign out_side  = side[QW];

  a_div_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> ##QW out_valid)
    else $error("divider lost a transfer");

endmodule

`default_nettype wire

// ----- rtl/core/cfe_taylor_cell.sv -----
// One Horner step of the exp series: p = 1 - (r*p)/N, three register ranks.
`default_nettype none

module cfe_taylor_cell #(
  parameter int N  = 1,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [31:0]   in_r,
  input  logic [32:0]   in_p,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [31:0]   out_r,
  output logic [32:0]   out_p,
  output logic [SW-1:0] out_side
);
  import cfe_pkg::*;

  localparam logic [36:0] RECIP = 37'((64'd1 << RECIP_SHIFT) / N);

  logic          v1, v2;
  logic [31:0]   r1, r2, t1, t2, qe2;
  logic [SW-1:0] s1, s2;
  logic [64:0]   prod1;
  logic [68:0]   prod2;
  logic [35:0]   qn, rem3;
  logic [31:0]   q3;

  assign prod1 = 65'(in_r) * 65'(in_p);
  assign prod2 = 69'(t1) * 69'(RECIP);
  assign qn    = 36'(qe2) * 36'(N);
  assign rem3  = 36'(t2) - qn;
  assign q3    = qe2 + 32'(rem3 >= 36'(N));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
    t1       <= prod1[63:32];
    r1       <= in_r;
    s1       <= in_side;
    t2       <= t1;
    qe2      <= prod2[67:36];
    r2       <= r1;
    s2       <= s1;
    out_p    <= ONE32 - 33'(q3);
    out_r    <= r2;
    out_side <= s2;
  end

endmodule

`default_nettype wire

// ----- rtl/core/cfe_exp.sv -----
// exp(-x) in Q1.32: range reduction by ln2, Horner series chain, rounded shift.
`default_nettype none

module cfe_exp #(
  parameter int SW = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [cfe_pkg::XW-1:0] in_x,
  input  logic [SW-1:0]         in_side,
  output logic                  out_valid,
  output logic [32:0]           out_eta,
  output logic [SW-1:0]         out_side
);
  import cfe_pkg::*;

  localparam int KS = SW + 1;
  localparam int TS = SW + 1 + KW;

  logic           v0;
  logic [XKW-1:0] x0;
  logic [KS-1:0]  s0;

  logic           kv;
  logic [KW-1:0]  kq;
  logic [XKW-1:0] krem;
  logic [KS-1:0]  ks;

  logic          tv [TAYLOR_TERMS+1];
  logic [31:0]   tr [TAYLOR_TERMS+1];
  logic [32:0]   tp [TAYLOR_TERMS+1];
  logic [TS-1:0] ts [TAYLOR_TERMS+1];

  logic [KW-1:0] k_end;
  logic          zero_end;
  logic [SW-1:0] side_end;
  logic [47:0]   rnd, wide, shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= in_valid;
    end
    x0 <= in_x[XKW-1:0];
    s0 <= {in_x >= EXP_LIMIT, in_side};
  end

  cfe_divider #(.W(XKW), .DW(32), .QW(KW), .SW(KS)) u_kdiv (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v0),
    .in_num   (x0),
    .in_den   (LN2_Q32),
    .in_side  (s0),
    .out_valid(kv),
    .out_quo  (kq),
    .out_rem  (krem),
    .out_side (ks)
  );

  assign tv[0] = kv;
  assign tr[0] = krem[31:0];
  assign tp[0] = ONE32;
  assign ts[0] = {kq, ks};

  for (genvar g = 0; g < TAYLOR_TERMS; g++) begin : g_term
    cfe_taylor_cell #(.N(TAYLOR_TERMS - g), .SW(TS)) u_term (
      .clk      (clk),
      .rst      (rst),
      .in_valid (tv[g]),
      .in_r     (tr[g]),
      .in_p     (tp[g]),
      .in_side  (ts[g]),
      .out_valid(tv[g+1]),
      .out_r    (tr[g+1]),
      .out_p    (tp[g+1]),
      .out_side (ts[g+1])
    );
  end

  assign {k_end, zero_end, side_end} = ts[TAYLOR_TERMS];
  assign rnd     = (k_end == '0) ? 48'd0 : (48'd1 << (k_end - KW'(1)));
  assign wide    = 48'(tp[TAYLOR_TERMS]) + rnd;
  assign shifted = wide >> k_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= tv[TAYLOR_TERMS];
    end
    out_eta  <= zero_end ? 33'd0 : shifted[32:0];
    out_side <= side_end;
  end

endmodule

`default_nettype wire

// ----- rtl/core/counterflow_effectiveness_from_ntu_unit.sv -----
// Top level: counterflow heat-exchanger effectiveness from NTU and capacity ratio.
//
// Usage:
//   Drive ntu_in and ratio_in (unsigned Q8.F) with start high; the item is
//   taken at a clock edge where start is high and busy is low. busy is high
//   during reset and in the cycle after it, so one item can enter every cycle.
//   Each item gives one result: effectiveness (Q1.F) on a one-cycle done
//   strobe, in input order. The result side cannot stall; results are
//   never held back.
//   The pipeline runs through the 32-cell reciprocal divider, the exp chain
//   (6 range cells and 14 series cells of three stages each), an (F+2)-bit
//   and an (F+1)-bit divider. Throughput is one item per cycle.
//   near_tolerance sits at byte address 0 of the register port; write it
//   only while no item is in flight. Reset loads it with 1 and empties the
//   pipeline.
`default_nettype none

module counterflow_effectiveness_from_ntu_unit #(
  parameter int FRAC_BITS = cfe_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [cfe_pkg::NTU_W-1:0]   ntu_in,
  input  logic [cfe_pkg::RATIO_W-1:0] ratio_in,
  output logic                        done,
  output logic [FRAC_BITS:0]          effectiveness,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cfe_pkg::APB_AW-1:0]  paddr,
  input  logic [cfe_pkg::APB_DW-1:0]  pwdata,
  output logic [cfe_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import cfe_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int WA = (F + 34 > 56) ? F + 34 : 56;
  localparam int WB = F + 35;
  localparam int WC = (2 * F + 2 > F + 25) ? 2 * F + 2 : F + 25;
  localparam int LAT = 90 + 2 * F;
  localparam logic [63:0] ONE_F = 64'd1 << F;
  localparam logic [F:0]  ONE_Q = ONE_F[F:0];

  typedef struct packed {
    logic        inv;
    logic [23:0] ntu;
    logic [23:0] ratio;
  } side_a_t;

  typedef struct packed {
    logic [32:0] c;
    logic [23:0] ntu;
    logic        inv;
    logic [23:0] ratio;
    logic        near_one;
    logic        near_zero;
  } side_e_t;

  typedef struct packed {
    logic        sel_z;
    logic [F:0]  eff_z;
    logic        inv;
    logic [23:0] ratio;
  } side_b_t;

  typedef struct packed {
    logic       inv;
    logic [F:0] eff;
  } side_c_t;

  // register port
  logic [TOL_W-1:0] tol;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[APB_AW-1] == REG_TOL) ? APB_DW'(tol) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (cfg_wr && paddr[APB_AW-1] == REG_TOL) begin
      tol <= pwdata[TOL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // input rank and scaled count
  logic        v1;
  logic [23:0] n1, r1;
  logic [47:0] prod1;
  logic [48:0] ntu_rnd;
  logic        inv1;
  logic [23:0] ntu1;
  logic [WA-1:0] num_a;
  side_a_t     sa_in, sa;
  logic        va;
  logic [31:0] qa;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start & ~busy;
    end
    n1    <= ntu_in;
    r1    <= ratio_in;
    prod1 <= 48'(ntu_in) * 48'(ratio_in);
  end

  assign inv1    = 64'(r1) > ONE_F;
  assign ntu_rnd = (49'(prod1) + 49'(ONE_F >> 1)) >> F;
  assign ntu1    = !inv1 ? n1 : (ntu_rnd > 49'(NTU_MAX)) ? NTU_MAX : ntu_rnd[23:0];
  assign num_a   = (WA'(1) << (32 + F)) + WA'(r1 >> 1);
  assign sa_in   = '{inv: inv1, ntu: ntu1, ratio: r1};

  cfe_divider #(.W(WA), .DW(24), .QW(32), .SW($bits(side_a_t))) u_div_c (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v1),
    .in_num   (num_a),
    .in_den   (r1),
    .in_side  (sa_in),
    .out_valid(va),
    .out_quo  (qa),
    .out_rem  (),
    .out_side (sa)
  );

  // effective ratio and case selection
  logic        v2, v3;
  logic [32:0] c2, d2, c3;
  logic [23:0] ntu2, r2, ntu3, r3;
  logic        inv2, inv3, one3, zero3;
  logic [47:0] tol32;
  logic [56:0] prod3;
  logic [XW-1:0] x4;
  side_e_t     se_in, se;
  logic        ve;
  logic [32:0] eta;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v2 <= va;
      v3 <= v2;
    end
    c2    <= sa.inv ? {1'b0, qa} : (33'(sa.ratio) << (32 - F));
    ntu2  <= sa.ntu;
    inv2  <= sa.inv;
    r2    <= sa.ratio;
    c3    <= c2;
    ntu3  <= ntu2;
    inv3  <= inv2;
    r3    <= r2;
    one3  <= 48'(d2) <= tol32;
    zero3 <= 48'(c2) < tol32;
    prod3 <= 57'(ntu2) * 57'(d2);
  end

  assign d2    = ONE32 - c2;
  assign tol32 = 48'(tol) << (32 - F);
  assign x4    = zero3 ? (XW'(ntu3) << (32 - F)) : XW'(prod3 >> F);
  assign se_in = '{c: c3, ntu: ntu3, inv: inv3, ratio: r3,
                   near_one: one3, near_zero: zero3};

  cfe_exp #(.SW($bits(side_e_t))) u_exp (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v3),
    .in_x     (x4),
    .in_side  (se_in),
    .out_valid(ve),
    .out_eta  (eta),
    .out_side (se)
  );

  // final quotient for the near-one and general cases
  logic        v5;
  logic [65:0] ce5;
  logic [32:0] num5, den5;
  logic [33:0] nz_sum, nz_shift;
  logic [F:0]  effz5;
  logic [23:0] ntu5, r5;
  logic        inv5, one5, zero5;
  logic [WB-1:0] num_b;
  logic [32:0] den_b, ntu_one;
  side_b_t     sb_in, sb;
  logic        vb;
  logic [F+1:0] qb;

  assign nz_sum   = 34'(ONE32 - eta) + (34'd1 << (31 - F));
  assign nz_shift = nz_sum >> (32 - F);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= ve;
    end
    ce5   <= 66'(eta) * 66'(se.c);
    num5  <= ONE32 - eta;
    effz5 <= nz_shift[F:0];
    ntu5  <= se.ntu;
    r5    <= se.ratio;
    inv5  <= se.inv;
    one5  <= se.near_one;
    zero5 <= se.near_zero;
  end

  assign den5    = ONE32 - ce5[64:32];
  assign ntu_one = 33'(ntu5) + 33'(ONE_F);
  assign num_b   = one5 ? (WB'(ntu5) << F) + WB'(ntu_one >> 1)
                        : (WB'(num5) << F) + WB'(den5 >> 1);
  assign den_b   = one5 ? ntu_one : den5;
  assign sb_in   = '{sel_z: !one5 && zero5, eff_z: effz5, inv: inv5, ratio: r5};

  cfe_divider #(.W(WB), .DW(33), .QW(F + 2), .SW($bits(side_b_t))) u_div_e (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v5),
    .in_num   (num_b),
    .in_den   (den_b),
    .in_side  (sb_in),
    .out_valid(vb),
    .out_quo  (qb),
    .out_rem  (),
    .out_side (sb)
  );

  // clamp, then scale back for an inverted ratio
  logic [F+1:0]  eff_pick;
  logic [F:0]    eff7;
  logic [WC-1:0] num_c;
  side_c_t       sc_in, sc;
  logic          vc;
  logic [F:0]    qc;

  assign eff_pick = sb.sel_z ? (F+2)'(sb.eff_z) : qb;
  assign eff7     = (eff_pick > (F+2)'(ONE_F)) ? ONE_Q : eff_pick[F:0];
  assign num_c    = (WC'(eff7) << F) + WC'(sb.ratio >> 1);
  assign sc_in    = '{inv: sb.inv, eff: eff7};

  cfe_divider #(.W(WC), .DW(24), .QW(F + 1), .SW($bits(side_c_t))) u_div_r (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vb),
    .in_num   (num_c),
    .in_den   (sb.ratio),
    .in_side  (sc_in),
    .out_valid(vc),
    .out_quo  (qc),
    .out_rem  (),
    .out_side (sc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vc;
    end
    effectiveness <= !sc.inv ? sc.eff : (qc > ONE_Q) ? ONE_Q : qc;
  end

  a_eff_range: assert property (@(posedge clk) disable iff (rst)
    done |-> effectiveness <= ONE_Q)
    else $error("effectiveness above one");

  a_busy_release: assert property (@(posedge clk)
    !rst |=> !busy)
    else $error("busy held outside reset");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("transfer did not complete on time");

endmodule

`default_nettype wire

// ----- sim/counterflow_effectiveness_from_ntu_unit_tb.sv -----
// Self-checking testbench for the counterflow effectiveness unit.
`timescale 1ns / 100ps

module counterflow_effectiveness_from_ntu_unit_tb;
  import cfe_pkg::*;

  localparam int F = FRAC_BITS_DEF;
  localparam longint unsigned ONE_F = 64'd1 << F;
  localparam longint unsigned ONE_Q32 = 64'd1 << 32;
  localparam int LATENCY = 90 + 2 * F;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [NTU_W-1:0] ntu_in = '0;
  logic [RATIO_W-1:0] ratio_in = '0;
  logic done;
  logic [F:0] effectiveness;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  logic [TOL_W-1:0] tolerance;
  logic [F:0] eff_queue[$];
  int errors = 0;
  int sender_idle_pct = 0;
  longint cycles = 0;

  counterflow_effectiveness_from_ntu_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .ntu_in(ntu_in), .ratio_in(ratio_in), .done(done),
    .effectiveness(effectiveness), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic longint unsigned exp_neg(longint unsigned x);
    longint unsigned k, r, p;
    if (x >= EXP_LIMIT) return 0;
    k = x / LN2_Q32;
    r = x - k * LN2_Q32;
    p = ONE_Q32;
    for (int n = TAYLOR_TERMS; n >= 1; n--)
      p = ONE_Q32 - ((r * p) >> 32) / longint'(n);
    if (k == 0) return p;
    return (p + (64'd1 << (k - 1))) >> k;
  endfunction

  function automatic logic [F:0] effectiveness_of(longint unsigned n, longint unsigned r);
    longint unsigned tol32, c32, ntu, eff, d32, eta, num, den;
    bit inv;
    tol32 = longint'(tolerance) << (32 - F);
    inv = r > ONE_F;
    if (!inv) begin
      c32 = r << (32 - F);
      ntu = n;
    end else begin
      c32 = ((64'd1 << (32 + F)) + r / 2) / r;
      ntu = (n * r + (ONE_F >> 1)) >> F;
      if (ntu > NTU_MAX) ntu = NTU_MAX;
    end
    if (ONE_Q32 - c32 <= tol32) begin
      eff = ((ntu << F) + (ntu + ONE_F) / 2) / (ntu + ONE_F);
    end else if (c32 < tol32) begin
      eff = (ONE_Q32 - exp_neg(ntu << (32 - F)) + (64'd1 << (31 - F))) >> (32 - F);
    end else begin
      d32 = ONE_Q32 - c32;
      eta = exp_neg((ntu * d32) >> F);
      num = ONE_Q32 - eta;
      den = ONE_Q32 - ((c32 * eta) >> 32);
      eff = ((num << F) + den / 2) / den;
    end
    if (eff > ONE_F) eff = ONE_F;
    if (inv) eff = ((eff << F) + r / 2) / r;
    if (eff > ONE_F) eff = ONE_F;
    return eff[F:0];
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (eff_queue.size() == 0) begin
        $error("effectiveness: unexpected transfer, actual %0d", effectiveness);
        errors++;
      end else begin
        if (eff_queue[0] !== effectiveness) begin
          $error("effectiveness: expected %0d actual %0d", eff_queue[0], effectiveness);
          errors++;
        end
        void'(eff_queue.pop_front());
      end
    end
  end

  task automatic send_item(logic [NTU_W-1:0] n, logic [RATIO_W-1:0] r);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    ntu_in <= n;
    ratio_in <= r;
    do @(posedge clk); while (busy);
    eff_queue.push_back(effectiveness_of(n, r));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (eff_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [TOL_W-1:0] v);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= APB_AW'(REG_TOL) << 2;
    pwdata <= APB_DW'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tolerance = v;
  endtask

  task automatic test_directed();
    send_item(24'd0, 24'd0);
    send_item(24'hFFFFFF, 24'd0);
    send_item(24'hFFFFFF, 24'hFFFFFF);
    send_item(24'd0, 24'hFFFFFF);
    send_item(24'(ONE_F), 24'(ONE_F));
    send_item(24'(ONE_F), 24'(ONE_F - 1));
    send_item(24'(ONE_F), 24'(ONE_F + 1));
    send_item(24'(3 * ONE_F), 24'd1);
    send_item(24'(2 * ONE_F), 24'(ONE_F / 2));
    send_item(24'(2 * ONE_F), 24'(2 * ONE_F));
    send_item(24'hFFFFFF, 24'h100000);
    send_item(24'h555555, 24'hAAAAAA);
    send_item(24'hAAAAAA, 24'h555555);
    send_item(24'd1, 24'h00FFFF);
    send_item(24'(40 * ONE_F), 24'(ONE_F / 4));
  endtask

  task automatic test_random(int count);
    logic [NTU_W-1:0] n;
    logic [RATIO_W-1:0] r;
    for (int i = 0; i < count; i++) begin
      n = (i % 3 == 0) ? 24'($urandom) : 24'($urandom_range(8 * ONE_F));
      case ($urandom_range(5))
        0: r = 24'($urandom);
        1: r = 24'(ONE_F - 24'($urandom_range(64)) + 24'($urandom_range(64)));
        2: r = 24'($urandom_range(64));
        3: r = 24'($urandom_range(ONE_F));
        default: r = 24'($urandom_range(4 * ONE_F));
      endcase
      send_item(n, r);
    end
  endtask

  initial begin
    tolerance = TOL_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    sender_idle_pct = 29;
    test_directed();
    test_random(200);
    write_tolerance(16'd0);
    test_directed();
    test_random(150);
    sender_idle_pct = 82;
    write_tolerance(16'hFFFF);
    test_directed();
    test_random(150);
    write_tolerance(16'd300);
    test_random(150);
    drain();
    sender_idle_pct = 0;
    write_tolerance(16'd5);
    test_random(200);
    drain();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
